@@ sv/fwdcc_pkg.sv @@
// Shared types and constants for the four-wheel drive command controller.
// No dependencies.
package fwdcc_pkg;

   localparam int unsigned NUM_WHEELS = 4;
   localparam logic [7:0] DUTY_MAX = 8'd255;
   localparam logic [7:0] MIN_DUTY_RESET = 8'd80;

   typedef enum logic [3:0] {
      KIND_TICK      = 4'd0,
      KIND_FWD       = 4'd1,
      KIND_BWD       = 4'd2,
      KIND_REV_WHEEL = 4'd3,
      KIND_REV_ALL   = 4'd4,
      KIND_ADJUST    = 4'd5,
      KIND_PIVOT_L   = 4'd6,
      KIND_PIVOT_R   = 4'd7,
      KIND_ARC_L     = 4'd8,
      KIND_ARC_R     = 4'd9,
      KIND_MOVE_F    = 4'd10,
      KIND_MOVE_B    = 4'd11,
      KIND_STOP      = 4'd12,
      KIND_SCHEDULE  = 4'd13
   } kind_type;

   // Saturate a requested duty to min_duty..255.
   function automatic logic [7:0] sat_duty(input logic [8:0] request,
                                           input logic [7:0] min_duty);
      logic [8:0] d;
      d = request;
      if (d < {1'b0, min_duty}) begin
         d = {1'b0, min_duty};
      end
      if (d > {1'b0, DUTY_MAX}) begin
         d = {1'b0, DUTY_MAX};
      end
      return d[7:0];
   endfunction

endpackage

@@ sv/four_wheel_drive_command_controller.sv @@
// Four-wheel drive command controller: wheel state, auto-stop timer, result register.
// Depends on fwdcc_pkg.

// One command or 1 ms tick beat is accepted per clock cycle. The wheel and
// timer state update happens in the cycle of acceptance, and the eight pin
// duties plus timer status are registered with it in a result register. The
// input is stalled only while the result register holds a beat that the
// downstream side is stalling. min_duty applies to commands accepted after
// the write; it resets to 80. Timed stops count accepted ticks; durations
// saturate to the TIMER_BITS-wide countdown.
module four_wheel_drive_command_controller #(
   parameter int unsigned TIMER_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [3:0] req_kind,
   input  logic [1:0] req_wheel_index,
   input  logic [8:0] req_speed,
   input  logic [8:0] req_outer_speed,
   input  logic signed [8:0] req_speed_delta,
   input  logic [15:0] req_duration_ms,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_left_back_fwd_duty,
   output logic [7:0] rsp_left_back_bwd_duty,
   output logic [7:0] rsp_left_front_fwd_duty,
   output logic [7:0] rsp_left_front_bwd_duty,
   output logic [7:0] rsp_right_front_fwd_duty,
   output logic [7:0] rsp_right_front_bwd_duty,
   output logic [7:0] rsp_right_back_fwd_duty,
   output logic [7:0] rsp_right_back_bwd_duty,
   output logic       rsp_auto_stopped,
   output logic       rsp_stop_pending
);
   import fwdcc_pkg::*;

   localparam int unsigned DUR_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;
   localparam logic [DUR_W-1:0] TIMER_MAX_W = DUR_W'({TIMER_BITS{1'b1}});

   logic [7:0] min_duty_ff;
   logic [7:0] duty_ff [NUM_WHEELS];
   logic [7:0] duty_in [NUM_WHEELS];
   logic       fwd_ff  [NUM_WHEELS];
   logic       fwd_in  [NUM_WHEELS];
   logic       armed_ff, armed_in;
   logic [TIMER_BITS-1:0] count_ff, count_in;
   logic       fired;

   logic       rsp_valid_ff;
   logic [7:0] pin_ff [2*NUM_WHEELS];
   logic       auto_stopped_ff, stop_pending_ff;

   logic       accept;
   logic [DUR_W-1:0] dur_w;
   logic [TIMER_BITS-1:0] dur_sat;
   logic signed [9:0] adj [NUM_WHEELS];
   logic [8:0] adj_clamp [NUM_WHEELS];
   logic [7:0] left_duty, right_duty;
   logic       left_fwd, right_fwd, sides_en;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign dur_w   = DUR_W'(req_duration_ms);
   assign dur_sat = (dur_w > TIMER_MAX_W) ? TIMER_BITS'(TIMER_MAX_W)
                                          : TIMER_BITS'(dur_w);

   always_comb begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
         adj[i] = $signed({2'b00, duty_ff[i]}) + 10'(req_speed_delta);
         if (adj[i] < 10'sd0) begin
            adj_clamp[i] = 9'd0;
         end else if (adj[i] > 10'sd255) begin
            adj_clamp[i] = 9'd255;
         end else begin
            adj_clamp[i] = adj[i][8:0];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
         duty_in[i] = duty_ff[i];
         fwd_in[i]  = fwd_ff[i];
      end
      armed_in   = armed_ff;
      count_in   = count_ff;
      fired      = 1'b0;
      sides_en   = 1'b0;
      left_duty  = sat_duty(req_speed, min_duty_ff);
      right_duty = sat_duty(req_speed, min_duty_ff);
      left_fwd   = 1'b1;
      right_fwd  = 1'b1;
      case (kind_type'(req_kind))
         KIND_TICK: begin
            if (armed_ff) begin
               if (count_ff <= TIMER_BITS'(1)) begin
                  fired    = 1'b1;
                  armed_in = 1'b0;
                  count_in = '0;
                  for (int i = 0; i < NUM_WHEELS; i++) begin
                     duty_in[i] = '0;
                  end
               end else begin
                  count_in = count_ff - TIMER_BITS'(1);
               end
            end
         end
         KIND_FWD, KIND_BWD: begin
            duty_in[req_wheel_index] = sat_duty(req_speed, min_duty_ff);
            fwd_in[req_wheel_index]  = (kind_type'(req_kind) == KIND_FWD);
         end
         KIND_REV_WHEEL: begin
            duty_in[req_wheel_index] = sat_duty({1'b0, duty_ff[req_wheel_index]},
                                                min_duty_ff);
            fwd_in[req_wheel_index]  = ~fwd_ff[req_wheel_index];
         end
         KIND_REV_ALL: begin
            for (int i = 0; i < NUM_WHEELS; i++) begin
               duty_in[i] = sat_duty({1'b0, duty_ff[i]}, min_duty_ff);
               fwd_in[i]  = ~fwd_ff[i];
            end
         end
         KIND_ADJUST: begin
            for (int i = 0; i < NUM_WHEELS; i++) begin
               duty_in[i] = sat_duty(adj_clamp[i], min_duty_ff);
            end
         end
         KIND_PIVOT_L: begin
            sides_en = 1'b1;
            left_fwd = 1'b0;
         end
         KIND_PIVOT_R: begin
            sides_en  = 1'b1;
            right_fwd = 1'b0;
         end
         KIND_ARC_L: begin
            sides_en   = 1'b1;
            right_duty = sat_duty(req_outer_speed, min_duty_ff);
         end
         KIND_ARC_R: begin
            sides_en  = 1'b1;
            left_duty = sat_duty(req_outer_speed, min_duty_ff);
         end
         KIND_MOVE_F, KIND_MOVE_B: begin
            sides_en  = 1'b1;
            left_fwd  = (kind_type'(req_kind) == KIND_MOVE_F);
            right_fwd = (kind_type'(req_kind) == KIND_MOVE_F);
         end
         KIND_STOP: begin
            armed_in = 1'b0;
            count_in = '0;
            for (int i = 0; i < NUM_WHEELS; i++) begin
               duty_in[i] = '0;
            end
         end
         KIND_SCHEDULE: begin
            armed_in = 1'b1;
            count_in = dur_sat;
         end
         default: begin
         end
      endcase
      if (sides_en) begin
         duty_in[0] = left_duty;
         duty_in[1] = left_duty;
         duty_in[2] = right_duty;
         duty_in[3] = right_duty;
         fwd_in[0]  = left_fwd;
         fwd_in[1]  = left_fwd;
         fwd_in[2]  = right_fwd;
         fwd_in[3]  = right_fwd;
         if ((req_kind inside {KIND_MOVE_F, KIND_MOVE_B}) && req_duration_ms != 16'd0) begin
            armed_in = 1'b1;
            count_in = dur_sat;
         end else begin
            armed_in = 1'b0;
            count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_duty_ff <= MIN_DUTY_RESET;
      end else if (csr_wr_en) begin
         min_duty_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_WHEELS; i++) begin
            duty_ff[i] <= '0;
            fwd_ff[i]  <= 1'b1;
         end
         armed_ff <= 1'b0;
         count_ff <= '0;
      end else if (accept) begin
         for (int i = 0; i < NUM_WHEELS; i++) begin
            duty_ff[i] <= duty_in[i];
            fwd_ff[i]  <= fwd_in[i];
         end
         armed_ff <= armed_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < NUM_WHEELS; i++) begin
            pin_ff[2*i]   <= fwd_in[i] ? duty_in[i] : 8'd0;
            pin_ff[2*i+1] <= fwd_in[i] ? 8'd0 : duty_in[i];
         end
         auto_stopped_ff <= fired;
         stop_pending_ff <= armed_in;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_left_back_fwd_duty   = pin_ff[0];
   assign rsp_left_back_bwd_duty   = pin_ff[1];
   assign rsp_left_front_fwd_duty  = pin_ff[2];
   assign rsp_left_front_bwd_duty  = pin_ff[3];
   assign rsp_right_front_fwd_duty = pin_ff[4];
   assign rsp_right_front_bwd_duty = pin_ff[5];
   assign rsp_right_back_fwd_duty  = pin_ff[6];
   assign rsp_right_back_bwd_duty  = pin_ff[7];
   assign rsp_auto_stopped         = auto_stopped_ff;
   assign rsp_stop_pending         = stop_pending_ff;

   // A disarmed timer always holds zero.
   a_disarmed_count_zero: assert property (@(posedge clock) disable iff (reset)
      !armed_ff |-> count_ff == '0)
      else $error("countdown nonzero while disarmed");

   // An auto-stop beat shows all wheels off and nothing pending.
   a_auto_stop_halts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && auto_stopped_ff |->
         pin_ff[0] == 8'd0 && pin_ff[1] == 8'd0 && pin_ff[2] == 8'd0 &&
         pin_ff[3] == 8'd0 && pin_ff[4] == 8'd0 && pin_ff[5] == 8'd0 &&
         pin_ff[6] == 8'd0 && pin_ff[7] == 8'd0 && !stop_pending_ff)
      else $error("auto stop left a wheel running");

   // Never both pins of one H-bridge driven.
   a_one_pin_per_wheel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         (pin_ff[0] == 8'd0 || pin_ff[1] == 8'd0) &&
         (pin_ff[2] == 8'd0 || pin_ff[3] == 8'd0) &&
         (pin_ff[4] == 8'd0 || pin_ff[5] == 8'd0) &&
         (pin_ff[6] == 8'd0 || pin_ff[7] == 8'd0))
      else $error("both pins of a wheel driven");

   // Every accepted beat produces a result beat next cycle.
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted beat produced no result");

endmodule

@@ test/tb_four_wheel_drive_command_controller.sv @@
// Self-checking testbench for four_wheel_drive_command_controller: directed and random
// drive commands, an in-bench wheel/timer predictor, and random stalls on both channels.
// Depends on fwdcc_pkg and the controller RTL.
module tb_four_wheel_drive_command_controller;
   timeunit 1ns;
   timeprecision 1ps;

   import fwdcc_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam logic [3:0] KIND_SPARE_LO = 4'd14;
   localparam logic [3:0] KIND_SPARE_HI = 4'd15;

   typedef struct packed {
      logic [3:0] kind;
      logic [1:0] wheel;
      logic [8:0] speed;
      logic [8:0] outer;
      logic signed [8:0] delta;
      logic [15:0] duration;
   } drive_cmd_type;

   // pin order: LB fwd, LB bwd, LF fwd, LF bwd, RF fwd, RF bwd, RB fwd, RB bwd
   typedef struct packed {
      logic [0:7][7:0] pin;
      logic auto_stopped;
      logic stop_pending;
   } wheel_pins_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [7:0] csr_wr_data = 8'd0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [3:0] req_kind = 4'd0;
   logic [1:0] req_wheel_index = 2'd0;
   logic [8:0] req_speed = 9'd0;
   logic [8:0] req_outer_speed = 9'd0;
   logic signed [8:0] req_speed_delta = 9'sd0;
   logic [15:0] req_duration_ms = 16'd0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [7:0] rsp_left_back_fwd_duty;
   logic [7:0] rsp_left_back_bwd_duty;
   logic [7:0] rsp_left_front_fwd_duty;
   logic [7:0] rsp_left_front_bwd_duty;
   logic [7:0] rsp_right_front_fwd_duty;
   logic [7:0] rsp_right_front_bwd_duty;
   logic [7:0] rsp_right_back_fwd_duty;
   logic [7:0] rsp_right_back_bwd_duty;
   logic rsp_auto_stopped;
   logic rsp_stop_pending;

   drive_cmd_type cmd_backlog[$];
   wheel_pins_type expected_pins[$];
   int unsigned cmds_queued = 0;
   int unsigned results_checked = 0;
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;
   int unsigned pause_odds = 0;
   int unsigned send_wait = 0;
   int unsigned hold_wait = 0;
   bit beat_taken = 1'b0;

   // predictor state
   logic [7:0] min_duty_now = MIN_DUTY_RESET;
   logic [7:0] duty_now [0:3] = '{default: 8'd0};
   logic heading_fwd [0:3] = '{default: 1'b1};
   logic timer_armed = 1'b0;
   logic [15:0] timer_left = 16'd0;

   four_wheel_drive_command_controller DUT (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_wheel_index(req_wheel_index),
      .req_speed(req_speed),
      .req_outer_speed(req_outer_speed),
      .req_speed_delta(req_speed_delta),
      .req_duration_ms(req_duration_ms),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_left_back_fwd_duty(rsp_left_back_fwd_duty),
      .rsp_left_back_bwd_duty(rsp_left_back_bwd_duty),
      .rsp_left_front_fwd_duty(rsp_left_front_fwd_duty),
      .rsp_left_front_bwd_duty(rsp_left_front_bwd_duty),
      .rsp_right_front_fwd_duty(rsp_right_front_fwd_duty),
      .rsp_right_front_bwd_duty(rsp_right_front_bwd_duty),
      .rsp_right_back_fwd_duty(rsp_right_back_fwd_duty),
      .rsp_right_back_bwd_duty(rsp_right_back_bwd_duty),
      .rsp_auto_stopped(rsp_auto_stopped),
      .rsp_stop_pending(rsp_stop_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void set_wheel(input int w, input int request, input logic forward);
      int d;
      d = request;
      if (d < int'(min_duty_now)) begin
         d = int'(min_duty_now);
      end
      if (d > 255) begin
         d = 255;
      end
      duty_now[w] = 8'(d);
      heading_fwd[w] = forward;
   endfunction

   function automatic void halt_wheels();
      int i;
      timer_armed = 1'b0;
      timer_left = 16'd0;
      for (i = 0; i < 4; i++) begin
         duty_now[i] = 8'd0;
      end
   endfunction

   function automatic void set_sides(input int left, input logic left_fwd,
                                     input int right, input logic right_fwd);
      timer_armed = 1'b0;
      timer_left = 16'd0;
      set_wheel(0, left, left_fwd);
      set_wheel(1, left, left_fwd);
      set_wheel(2, right, right_fwd);
      set_wheel(3, right, right_fwd);
   endfunction

   function automatic void arm_stop(input logic [15:0] dur);
      timer_armed = 1'b1;
      timer_left = dur;
   endfunction

   function automatic wheel_pins_type predict_pins(input drive_cmd_type c);
      wheel_pins_type r;
      int i;
      int v;
      r = '0;
      case (c.kind)
         KIND_TICK: begin
            if (timer_armed) begin
               if (timer_left <= 16'd1) begin
                  halt_wheels();
                  r.auto_stopped = 1'b1;
               end else begin
                  timer_left = timer_left - 16'd1;
               end
            end
         end
         KIND_FWD: set_wheel(int'(c.wheel), int'(c.speed), 1'b1);
         KIND_BWD: set_wheel(int'(c.wheel), int'(c.speed), 1'b0);
         KIND_REV_WHEEL: set_wheel(int'(c.wheel), int'(duty_now[c.wheel]),
                                   !heading_fwd[c.wheel]);
         KIND_REV_ALL: begin
            for (i = 0; i < 4; i++) begin
               set_wheel(i, int'(duty_now[i]), !heading_fwd[i]);
            end
         end
         KIND_ADJUST: begin
            for (i = 0; i < 4; i++) begin
               v = int'(duty_now[i]) + int'($signed(c.delta));
               if (v < 0) begin
                  v = 0;
               end
               if (v > 255) begin
                  v = 255;
               end
               set_wheel(i, v, heading_fwd[i]);
            end
         end
         KIND_PIVOT_L: set_sides(int'(c.speed), 1'b0, int'(c.speed), 1'b1);
         KIND_PIVOT_R: set_sides(int'(c.speed), 1'b1, int'(c.speed), 1'b0);
         KIND_ARC_L: set_sides(int'(c.speed), 1'b1, int'(c.outer), 1'b1);
         KIND_ARC_R: set_sides(int'(c.outer), 1'b1, int'(c.speed), 1'b1);
         KIND_MOVE_F: begin
            set_sides(int'(c.speed), 1'b1, int'(c.speed), 1'b1);
            if (c.duration != 16'd0) begin
               arm_stop(c.duration);
            end
         end
         KIND_MOVE_B: begin
            set_sides(int'(c.speed), 1'b0, int'(c.speed), 1'b0);
            if (c.duration != 16'd0) begin
               arm_stop(c.duration);
            end
         end
         KIND_STOP: halt_wheels();
         KIND_SCHEDULE: arm_stop(c.duration);
         default: ;
      endcase
      for (i = 0; i < 4; i++) begin
         r.pin[2 * i] = heading_fwd[i] ? duty_now[i] : 8'd0;
         r.pin[2 * i + 1] = heading_fwd[i] ? 8'd0 : duty_now[i];
      end
      r.stop_pending = timer_armed;
      return r;
   endfunction

   task automatic check_pins(input wheel_pins_type got);
      wheel_pins_type want;
      bit bad;
      int i;
      if (expected_pins.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t: unexpected result beat %h", $time, got);
         end
      end else begin
         want = expected_pins.pop_front();
         bad = 1'b0;
         for (i = 0; i < 8; i++) begin
            if (got.pin[i] !== want.pin[i]) begin
               bad = 1'b1;
            end
         end
         if (got.auto_stopped !== want.auto_stopped || got.stop_pending !== want.stop_pending) begin
            bad = 1'b1;
         end
         if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: pins exp %h got %h, auto_stopped exp %b got %b, stop_pending exp %b got %b",
                        $time, want.pin, got.pin, want.auto_stopped, got.auto_stopped,
                        want.stop_pending, got.stop_pending);
            end
         end
      end
   endtask

   always @(posedge clock) begin : monitor
      drive_cmd_type c;
      wheel_pins_type got;
      beat_taken = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.pin = {rsp_left_back_fwd_duty, rsp_left_back_bwd_duty,
                       rsp_left_front_fwd_duty, rsp_left_front_bwd_duty,
                       rsp_right_front_fwd_duty, rsp_right_front_bwd_duty,
                       rsp_right_back_fwd_duty, rsp_right_back_bwd_duty};
            got.auto_stopped = rsp_auto_stopped;
            got.stop_pending = rsp_stop_pending;
            check_pins(got);
            results_checked++;
         end
         if (req_valid && !req_stall) begin
            c.kind = req_kind;
            c.wheel = req_wheel_index;
            c.speed = req_speed;
            c.outer = req_outer_speed;
            c.delta = req_speed_delta;
            c.duration = req_duration_ms;
            expected_pins.push_back(predict_pins(c));
            beat_taken = 1'b1;
         end
      end
   end

   always @(negedge clock) begin : driver
      drive_cmd_type c;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || beat_taken) begin
         if (send_wait > 0) begin
            send_wait--;
            req_valid <= 1'b0;
         end else if (cmd_backlog.size() != 0) begin
            c = cmd_backlog.pop_front();
            req_kind <= c.kind;
            req_wheel_index <= c.wheel;
            req_speed <= c.speed;
            req_outer_speed <= c.outer;
            req_speed_delta <= c.delta;
            req_duration_ms <= c.duration;
            req_valid <= 1'b1;
            if (pause_odds != 0 && $urandom_range(1, pause_odds) == 1) begin
               send_wait = $urandom_range(1, 17);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_wait > 0) begin
         hold_wait--;
         rsp_stall <= 1'b1;
      end else if (pause_odds != 0 && $urandom_range(1, pause_odds) == 1) begin
         hold_wait = $urandom_range(0, 16);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_four_wheel_drive_command_controller failed");
         $finish;
      end
   end

   function automatic drive_cmd_type cmd(input logic [3:0] kind, input int wheel, input int speed,
                                         input int outer, input int delta, input int dur);
      drive_cmd_type c;
      c.kind = kind;
      c.wheel = 2'(wheel);
      c.speed = 9'(speed);
      c.outer = 9'(outer);
      c.delta = 9'(delta);
      c.duration = 16'(dur);
      return c;
   endfunction

   function automatic logic [8:0] random_speed();
      logic [8:0] s;
      case ($urandom_range(0, 3))
         0: s = 9'($urandom_range(0, 511));
         1: s = 9'($urandom_range(0, 10));
         2: s = 9'($urandom_range(250, 511));
         default: s = 9'($urandom_range(60, 260));
      endcase
      return s;
   endfunction

   function automatic drive_cmd_type random_cmd();
      drive_cmd_type c;
      int unsigned pick;
      if ($urandom_range(0, 99) < 35) begin
         c.kind = KIND_TICK;
      end else begin
         c.kind = 4'($urandom_range(0, 15));
      end
      c.wheel = 2'($urandom_range(0, 3));
      c.speed = random_speed();
      c.outer = random_speed();
      c.delta = 9'($urandom_range(0, 511));
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         c.duration = 16'($urandom_range(0, 6));
      end else if (pick < 9) begin
         c.duration = 16'($urandom_range(7, 300));
      end else begin
         c.duration = 16'($urandom_range(0, 65535));
      end
      return c;
   endfunction

   task automatic queue_cmd(input drive_cmd_type c);
      cmd_backlog.push_back(c);
      cmds_queued++;
   endtask

   // timed-stop sequences get ticks right behind them so the countdown actually fires
   task automatic random_phase(input int count);
      drive_cmd_type c;
      drive_cmd_type t;
      int n;
      int k;
      n = 0;
      while (n < count) begin
         c = random_cmd();
         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 2))
               0: c.kind = KIND_SCHEDULE;
               1: c.kind = KIND_MOVE_F;
               default: c.kind = KIND_MOVE_B;
            endcase
            c.duration = 16'($urandom_range(1, 6));
            queue_cmd(c);
            n++;
            for (k = 0; k <= int'(c.duration); k++) begin
               t = random_cmd();
               t.kind = KIND_TICK;
               queue_cmd(t);
               n++;
            end
         end else begin
            queue_cmd(c);
            n++;
         end
      end
   endtask

   task automatic settle();
      while (results_checked < cmds_queued) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic write_min_duty(input logic [7:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      min_duty_now = value;
      @(posedge clock);
   endtask

   initial begin : sequencer
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      pause_odds = 6;
      queue_cmd(cmd(KIND_TICK, 0, 511, 511, 255, 65535));
      queue_cmd(cmd(KIND_REV_WHEEL, 0, 0, 0, 0, 0));
      queue_cmd(cmd(KIND_FWD, 1, 0, 0, 0, 0));
      queue_cmd(cmd(KIND_BWD, 2, 511, 0, 0, 0));
      queue_cmd(cmd(KIND_FWD, 3, 200, 0, 0, 0));
      queue_cmd(cmd(KIND_REV_ALL, 0, 0, 0, 0, 0));
      queue_cmd(cmd(KIND_ADJUST, 0, 0, 0, -255, 0));
      queue_cmd(cmd(KIND_ADJUST, 0, 0, 0, 255, 0));
      queue_cmd(cmd(KIND_ADJUST, 0, 0, 0, -256, 0));
      queue_cmd(cmd(KIND_PIVOT_L, 0, 100, 0, 0, 0));
      queue_cmd(cmd(KIND_PIVOT_R, 0, 300, 0, 0, 0));
      queue_cmd(cmd(KIND_ARC_L, 0, 90, 511, 0, 0));
      queue_cmd(cmd(KIND_ARC_R, 0, 0, 170, 0, 0));
      queue_cmd(cmd(KIND_MOVE_F, 0, 120, 0, 0, 0));
      queue_cmd(cmd(KIND_MOVE_B, 0, 255, 0, 0, 2));
      queue_cmd(cmd(KIND_TICK, 0, 0, 0, 0, 0));
      queue_cmd(cmd(KIND_TICK, 0, 0, 0, 0, 0));
      queue_cmd(cmd(KIND_SCHEDULE, 0, 0, 0, 0, 0));
      queue_cmd(cmd(KIND_TICK, 0, 0, 0, 0, 0));
      queue_cmd(cmd(KIND_MOVE_F, 3, 60, 0, 0, 65535));
      queue_cmd(cmd(KIND_TICK, 0, 0, 0, 0, 0));
      queue_cmd(cmd(KIND_FWD, 0, 255, 0, 0, 0));
      queue_cmd(cmd(KIND_STOP, 0, 0, 0, 0, 0));
      queue_cmd(cmd(KIND_SPARE_LO, 1, 77, 88, 9, 10));
      queue_cmd(cmd(KIND_SPARE_HI, 2, 511, 511, -1, 65535));
      settle();

      write_min_duty(8'd0);
      pause_odds = 4;
      random_phase(400);
      settle();

      write_min_duty(DUTY_MAX);
      pause_odds = 0;
      random_phase(250);
      settle();

      write_min_duty(8'($urandom_range(1, 254)));
      pause_odds = 10;
      random_phase(400);
      settle();

      write_min_duty(MIN_DUTY_RESET);
      pause_odds = 3;
      random_phase(350);
      settle();

      write_min_duty(8'($urandom_range(0, 255)));
      pause_odds = 0;
      random_phase(300);
      settle();

      repeat (8) @(posedge clock);
      if (expected_pins.size() != 0) begin
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("tb_four_wheel_drive_command_controller passed");
      end else begin
         $display("tb_four_wheel_drive_command_controller failed");
      end
      $finish;
   end

endmodule

@@ four_wheel_drive_command_controller.f @@
sv/fwdcc_pkg.sv
sv/four_wheel_drive_command_controller.sv
test/tb_four_wheel_drive_command_controller.sv
